/* sv/mesh_vertex_normal_averager_core_macros.svh */
// Assertion macros shared by the mesh vertex normal averager RTL.
`ifndef MESH_VERTEX_NORMAL_AVERAGER_CORE_MACROS_SVH
`define MESH_VERTEX_NORMAL_AVERAGER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled during reset.
`define MVNA_ASSERT_IMPL(label, pre, post, msg) \
label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
   else $error(msg);

// Next-cycle implication, sampled on clock and disabled during reset.
`define MVNA_ASSERT_NEXT(label, pre, post, msg) \
label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
   else $error(msg);

`endif

/* sv/mvna_pkg.sv */
// Types and constants of the mesh vertex normal averager.
`default_nettype none

package mvna_pkg;

   localparam int VERTEX_DEPTH = 4096;
   localparam int ADDR_W       = $clog2(VERTEX_DEPTH);
   localparam int SUM_W        = 24;
   localparam int CNT_W        = 8;
   localparam int QUO_W        = 26;
   localparam int ONE_Q14      = 16384;

   localparam logic [1:0] KIND_STORE = 2'd0;
   localparam logic [1:0] KIND_FACE  = 2'd1;
   localparam logic [1:0] KIND_QUERY = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [11:0]        vertex_index;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic [12:0]        corner_a;
      logic [12:0]        corner_b;
      logic [12:0]        corner_c;
   } req_type;

   typedef struct packed {
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               no_faces;
   } rsp_type;

   typedef struct packed {
      logic [CNT_W-1:0]        count;
      logic signed [SUM_W-1:0] sum_x;
      logic signed [SUM_W-1:0] sum_y;
      logic signed [SUM_W-1:0] sum_z;
   } sum_word_type;

   typedef struct packed {
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
   } pos_word_type;

endpackage

`default_nettype wire

/* sv/mesh_vertex_normal_averager_core.sv */
// Top level of the mesh vertex normal averager: sequencer, stores and arithmetic.
//
// Usage: an item on req_data is taken at a clock edge where start is high and
// busy is low. Kind store writes a vertex position; busy does not rise. Kind
// face reads the three corner positions, forms the cross product with one shared
// 32x32 multiplier, normalizes it with a bit-serial square root and a restoring
// divider, then read-modify-writes the sum store once per corner. The cross
// product is shifted down until it fits 30 bits; a face whose cross product is
// zero leaves the sum store unchanged. Kind query reads the sum store and returns
// one result; for a vertex with faces it first does three divisions by the face
// count. The result is on rsp_data for exactly one cycle with rsp_valid high;
// the receiver cannot stall it. csr_wen writes the normal sign, used by later
// queries. After reset the block clears all VERTEX_DEPTH (4096) entries of the
// sum store, one entry per cycle, with busy high. Positions are not cleared.
`default_nettype none

`include "mesh_vertex_normal_averager_core_macros.svh"

module mesh_vertex_normal_averager_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire mvna_pkg::req_type req_data,
   output logic                   rsp_valid,
   output mvna_pkg::rsp_type      rsp_data,
   input  wire logic              csr_wen,
   input  wire logic [1:0]        csr_wdata
);

   localparam int AW = mvna_pkg::ADDR_W;
   localparam int QW = mvna_pkg::QUO_W;

   localparam logic [3:0] ST_CLR  = 4'd0;
   localparam logic [3:0] ST_IDLE = 4'd1;
   localparam logic [3:0] ST_PRD  = 4'd2;
   localparam logic [3:0] ST_EDGE = 4'd3;
   localparam logic [3:0] ST_MUL  = 4'd4;
   localparam logic [3:0] ST_CMAG = 4'd5;
   localparam logic [3:0] ST_CSHF = 4'd6;
   localparam logic [3:0] ST_SQ   = 4'd7;
   localparam logic [3:0] ST_SQRT = 4'd8;
   localparam logic [3:0] ST_DSET = 4'd9;
   localparam logic [3:0] ST_DIV  = 4'd10;
   localparam logic [3:0] ST_DEND = 4'd11;
   localparam logic [3:0] ST_ARD  = 4'd12;
   localparam logic [3:0] ST_AWR  = 4'd13;
   localparam logic [3:0] ST_QCHK = 4'd14;
   localparam logic [3:0] ST_QOUT = 4'd15;

   // Memories
   mvna_pkg::pos_word_type pos_mem [mvna_pkg::VERTEX_DEPTH];
   mvna_pkg::sum_word_type sum_mem [mvna_pkg::VERTEX_DEPTH];

   logic                   pos_we;
   logic [AW-1:0]          pos_waddr;
   mvna_pkg::pos_word_type pos_wdata;
   logic [AW-1:0]          pos_raddr;
   mvna_pkg::pos_word_type pos_rd_ff;
   logic                   sum_we;
   logic [AW-1:0]          sum_waddr;
   mvna_pkg::sum_word_type sum_wdata;
   logic [AW-1:0]          sum_raddr;
   mvna_pkg::sum_word_type sum_rd_ff;

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[pos_waddr] <= pos_wdata;
      end
      pos_rd_ff <= pos_mem[pos_raddr];
   end

   always_ff @(posedge clock) begin
      if (sum_we) begin
         sum_mem[sum_waddr] <= sum_wdata;
      end
      sum_rd_ff <= sum_mem[sum_raddr];
   end

   // Registers
   logic [3:0]         state_ff, state_in;
   logic [5:0]         step_ff, step_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [1:0]         dix_ff, dix_in;
   logic               face_ff, face_in;
   logic [AW-1:0]      cidx_ff [3];
   logic [AW-1:0]      cidx_in [3];
   logic [AW-1:0]      qidx_ff, qidx_in;
   logic signed [31:0] pa_ff [3];
   logic signed [31:0] pb_ff [3];
   logic signed [31:0] pc_ff [3];
   logic signed [31:0] pa_in [3];
   logic signed [31:0] pb_in [3];
   logic signed [31:0] pc_in [3];
   logic signed [31:0] e_ff [6];
   logic signed [31:0] e_in [6];
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] c_ff [3];
   logic signed [63:0] c_in [3];
   logic [63:0]        m_ff, m_in;
   logic [63:0]        v_ff, v_in;
   logic [63:0]        r_ff, r_in;
   logic [63:0]        sbit_ff, sbit_in;
   logic [31:0]        len_ff, len_in;
   logic [34:0]        rem_ff, rem_in;
   logic [QW-1:0]      quo_ff, quo_in;
   logic [33:0]        den_ff, den_in;
   logic               neg_ff, neg_in;
   logic signed [15:0] n_ff [3];
   logic signed [15:0] n_in [3];
   logic signed [mvna_pkg::SUM_W-1:0] sum_ff [3];
   logic signed [mvna_pkg::SUM_W-1:0] sum_in [3];
   logic [mvna_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic signed [1:0]  sign_ff, sign_in;
   logic               rsp_valid_ff, rsp_valid_in;
   mvna_pkg::rsp_type  rsp_ff, rsp_in;

   // Combinational helpers
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic signed [32:0] er [6];
   logic [32:0]        emag [6];
   logic [32:0]        eor;
   logic [1:0]         eshift;
   logic [2:0]         jj;
   logic [1:0]         cj;
   logic [63:0]        rb;
   logic [31:0]        cmag;
   logic signed [25:0] qp;
   logic [25:0]        qmag;
   logic [47:0]        dnum;
   logic [35:0]        dsh;
   logic [14:0]        qclamp;
   logic [12:0]        corner [3];
   logic               corner_bad;
   logic signed [mvna_pkg::SUM_W:0] acc [3];
   logic signed [mvna_pkg::SUM_W-1:0] accs [3];
   logic               q_in_range;

   assign mul_p = mul_a * mul_b;
   assign busy  = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      corner[0] = req_data.corner_a;
      corner[1] = req_data.corner_b;
      corner[2] = req_data.corner_c;
      corner_bad = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (corner[i] == 13'd0 || 32'(corner[i]) > 32'(mvna_pkg::VERTEX_DEPTH)) begin
            corner_bad = 1'b1;
         end
      end
      q_in_range = (32'(req_data.vertex_index) < 32'(mvna_pkg::VERTEX_DEPTH));
   end

   // Edge vectors and their common shift, which is at most three bits.
   always_comb begin
      eor = '0;
      for (int i = 0; i < 3; i++) begin
         er[i]     = 33'(pb_ff[i]) - 33'(pa_ff[i]);
         er[i + 3] = 33'(pc_ff[i]) - 33'(pb_ff[i]);
      end
      for (int i = 0; i < 6; i++) begin
         emag[i] = er[i][32] ? 33'(-er[i]) : 33'(er[i]);
         eor     = eor | emag[i];
      end
      if (eor[32]) begin
         eshift = 2'd3;
      end else if (eor[31]) begin
         eshift = 2'd2;
      end else if (eor[30]) begin
         eshift = 2'd1;
      end else begin
         eshift = 2'd0;
      end
   end

   // Operands of the shared multiplier.
   always_comb begin
      mul_a = e_ff[1];
      mul_b = e_ff[5];
      if (state_ff == ST_SQ) begin
         case (step_ff[1:0])
            2'd0:    mul_a = c_ff[0][31:0];
            2'd1:    mul_a = c_ff[1][31:0];
            default: mul_a = c_ff[2][31:0];
         endcase
         mul_b = mul_a;
      end else begin
         case (step_ff[2:0])
            3'd0: begin mul_a = e_ff[1]; mul_b = e_ff[5]; end
            3'd1: begin mul_a = e_ff[2]; mul_b = e_ff[4]; end
            3'd2: begin mul_a = e_ff[2]; mul_b = e_ff[3]; end
            3'd3: begin mul_a = e_ff[0]; mul_b = e_ff[5]; end
            3'd4: begin mul_a = e_ff[0]; mul_b = e_ff[4]; end
            default: begin mul_a = e_ff[1]; mul_b = e_ff[3]; end
         endcase
      end
   end

   always_comb begin
      jj   = step_ff[2:0] - 3'd1;
      cj   = jj[2:1];
      rb   = r_ff + sbit_ff;
      cmag = c_ff[dix_ff][31] ? 32'(-c_ff[dix_ff][31:0]) : c_ff[dix_ff][31:0];
      qp   = 26'(sign_ff) * 26'(sum_ff[dix_ff]);
      qmag = qp[25] ? 26'(-qp) : 26'(qp);
      if (face_ff) begin
         dnum = 48'({cmag, 15'b0}) + 48'(len_ff);
      end else begin
         dnum = 48'({qmag, 1'b0}) + 48'(cnt_ff);
      end
      dsh = {rem_ff, quo_ff[QW-1]};
      if (quo_ff > QW'(mvna_pkg::ONE_Q14)) begin
         qclamp = 15'(mvna_pkg::ONE_Q14);
      end else begin
         qclamp = quo_ff[14:0];
      end
      for (int i = 0; i < 3; i++) begin
         acc[i] = 25'(n_ff[i]);
      end
      acc[0] = acc[0] + 25'(sum_rd_ff.sum_x);
      acc[1] = acc[1] + 25'(sum_rd_ff.sum_y);
      acc[2] = acc[2] + 25'(sum_rd_ff.sum_z);
      for (int i = 0; i < 3; i++) begin
         if (acc[i] > 25'sd8388607) begin
            accs[i] = 24'sd8388607;
         end else if (acc[i] < -25'sd8388608) begin
            accs[i] = -24'sd8388608;
         end else begin
            accs[i] = acc[i][23:0];
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      clr_in       = clr_ff;
      dix_in       = dix_ff;
      face_in      = face_ff;
      qidx_in      = qidx_ff;
      prod_in      = prod_ff;
      m_in         = m_ff;
      v_in         = v_ff;
      r_in         = r_ff;
      sbit_in      = sbit_ff;
      len_in       = len_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      den_in       = den_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      sign_in      = csr_wen ? csr_wdata : sign_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      for (int i = 0; i < 3; i++) begin
         cidx_in[i] = cidx_ff[i];
         pa_in[i]   = pa_ff[i];
         pb_in[i]   = pb_ff[i];
         pc_in[i]   = pc_ff[i];
         c_in[i]    = c_ff[i];
         n_in[i]    = n_ff[i];
         sum_in[i]  = sum_ff[i];
      end
      for (int i = 0; i < 6; i++) begin
         e_in[i] = e_ff[i];
      end
      pos_we    = 1'b0;
      pos_waddr = AW'(req_data.vertex_index);
      pos_wdata = '{x: req_data.pos_x, y: req_data.pos_y, z: req_data.pos_z};
      pos_raddr = cidx_ff[0];
      sum_we    = 1'b0;
      sum_waddr = cidx_ff[dix_ff];
      sum_wdata = '{count: cnt_ff, sum_x: accs[0], sum_y: accs[1], sum_z: accs[2]};
      sum_raddr = cidx_ff[dix_ff];

      unique case (state_ff)
         ST_CLR: begin
            sum_we    = 1'b1;
            sum_waddr = clr_ff;
            sum_wdata = '0;
            clr_in    = clr_ff + AW'(1);
            if (32'(clr_ff) == mvna_pkg::VERTEX_DEPTH - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               case (req_data.kind)
                  mvna_pkg::KIND_STORE: begin
                     pos_we = q_in_range;
                  end
                  mvna_pkg::KIND_FACE: begin
                     for (int i = 0; i < 3; i++) begin
                        cidx_in[i] = AW'(corner[i] - 13'd1);
                     end
                     face_in  = 1'b1;
                     step_in  = '0;
                     state_in = corner_bad ? ST_IDLE : ST_PRD;
                     if (corner_bad) begin
                        // A face with a corner out of range is dropped; keep
                        // busy high for one cycle so the item is visibly taken.
                        state_in = ST_QCHK;
                        face_in  = 1'b1;
                     end
                  end
                  mvna_pkg::KIND_QUERY: begin
                     face_in  = 1'b0;
                     qidx_in  = AW'(req_data.vertex_index);
                     dix_in   = '0;
                     cidx_in[0] = AW'(req_data.vertex_index);
                     neg_in   = !q_in_range;
                     state_in = ST_QCHK;
                     step_in  = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PRD: begin
            // Corner reads go out on steps 0 to 2; the registered read data is taken on steps 1 to 3.
            case (step_ff[1:0])
               2'd0:    pos_raddr = cidx_ff[0];
               2'd1:    pos_raddr = cidx_ff[1];
               default: pos_raddr = cidx_ff[2];
            endcase
            if (step_ff[1:0] == 2'd1) begin
               pa_in[0] = pos_rd_ff.x; pa_in[1] = pos_rd_ff.y; pa_in[2] = pos_rd_ff.z;
            end
            if (step_ff[1:0] == 2'd2) begin
               pb_in[0] = pos_rd_ff.x; pb_in[1] = pos_rd_ff.y; pb_in[2] = pos_rd_ff.z;
            end
            step_in = step_ff + 6'd1;
            if (step_ff[1:0] == 2'd3) begin
               pc_in[0] = pos_rd_ff.x; pc_in[1] = pos_rd_ff.y; pc_in[2] = pos_rd_ff.z;
               state_in = ST_EDGE;
            end
         end
         ST_EDGE: begin
            for (int i = 0; i < 6; i++) begin
               e_in[i] = 32'(er[i] >>> eshift);
            end
            step_in  = '0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            if (step_ff < 6'd6) begin
               prod_in = mul_p;
            end
            if (step_ff != 6'd0) begin
               if (jj[0]) begin
                  c_in[cj] = c_ff[cj] - prod_ff;
               end else begin
                  c_in[cj] = prod_ff;
               end
            end
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd6) begin
               state_in = ST_CMAG;
            end
         end
         ST_CMAG: begin
            m_in = '0;
            for (int i = 0; i < 3; i++) begin
               m_in = m_in | (c_ff[i][63] ? 64'(-c_ff[i]) : 64'(c_ff[i]));
            end
            state_in = ST_CSHF;
         end
         ST_CSHF: begin
            // One floor shift per cycle until the largest magnitude fits 30 bits.
            if (m_ff[63:30] != '0) begin
               for (int i = 0; i < 3; i++) begin
                  c_in[i] = c_ff[i] >>> 1;
               end
               m_in = m_ff >> 1;
            end else if (m_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               v_in     = '0;
               step_in  = '0;
               state_in = ST_SQ;
            end
         end
         ST_SQ: begin
            if (step_ff < 6'd3) begin
               prod_in = mul_p;
            end
            if (step_ff != 6'd0) begin
               v_in = v_ff + 64'(prod_ff);
            end
            step_in = step_ff + 6'd1;
            if (step_ff == 6'd3) begin
               r_in     = '0;
               sbit_in  = 64'(1) << 62;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sbit_ff != '0) begin
               if (v_ff >= rb) begin
                  v_in = v_ff - rb;
                  r_in = (r_ff >> 1) + sbit_ff;
               end else begin
                  r_in = r_ff >> 1;
               end
               sbit_in = sbit_ff >> 2;
            end else begin
               len_in   = r_ff[31:0];
               dix_in   = '0;
               state_in = ST_DSET;
            end
         end
         ST_DSET: begin
            rem_in = 35'(dnum[47:QW]);
            quo_in = dnum[QW-1:0];
            if (face_ff) begin
               den_in = 34'({len_ff, 1'b0});
               neg_in = (c_ff[dix_ff] > 64'sd0);
            end else begin
               den_in = 34'({cnt_ff, 1'b0});
               neg_in = qp[25];
            end
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            if (dsh >= 36'(den_ff)) begin
               rem_in = 35'(dsh - 36'(den_ff));
               quo_in = {quo_ff[QW-2:0], 1'b1};
            end else begin
               rem_in = dsh[34:0];
               quo_in = {quo_ff[QW-2:0], 1'b0};
            end
            step_in = step_ff + 6'd1;
            if (32'(step_ff) == QW - 1) begin
               state_in = ST_DEND;
            end
         end
         ST_DEND: begin
            n_in[dix_ff] = neg_ff ? -16'(qclamp) : 16'(qclamp);
            if (dix_ff == 2'd2) begin
               dix_in   = '0;
               state_in = face_ff ? ST_ARD : ST_QOUT;
            end else begin
               dix_in   = dix_ff + 2'd1;
               state_in = ST_DSET;
            end
         end
         ST_ARD: begin
            state_in = ST_AWR;
         end
         ST_AWR: begin
            // The next corner is read only after this write, so repeated
            // corners see their own updates.
            sum_we = 1'b1;
            sum_wdata.count = (sum_rd_ff.count == '1) ? sum_rd_ff.count
                                                      : sum_rd_ff.count + 8'd1;
            if (dix_ff == 2'd2) begin
               state_in = ST_IDLE;
            end else begin
               dix_in   = dix_ff + 2'd1;
               state_in = ST_ARD;
            end
         end
         ST_QCHK: begin
            if (face_ff) begin
               state_in = ST_IDLE;
            end else if (step_ff == 6'd0) begin
               sum_raddr = qidx_ff;
               step_in   = 6'd1;
            end else if (step_ff == 6'd1) begin
               step_in = 6'd2;
            end else begin
               sum_in[0] = sum_rd_ff.sum_x;
               sum_in[1] = sum_rd_ff.sum_y;
               sum_in[2] = sum_rd_ff.sum_z;
               cnt_in    = sum_rd_ff.count;
               if (neg_ff || sum_rd_ff.count == '0) begin
                  rsp_valid_in = 1'b1;
                  rsp_in       = '{normal_x: '0, normal_y: '0, normal_z: '0, no_faces: 1'b1};
                  state_in     = ST_IDLE;
               end else begin
                  dix_in   = '0;
                  state_in = ST_DSET;
               end
            end
         end
         ST_QOUT: begin
            rsp_valid_in = 1'b1;
            rsp_in = '{normal_x: n_ff[0], normal_y: n_ff[1], normal_z: n_ff[2],
                       no_faces: 1'b0};
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLR;
         clr_ff       <= '0;
         step_ff      <= '0;
         dix_ff       <= '0;
         face_ff      <= 1'b0;
         sign_ff      <= 2'sd1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         step_ff      <= step_in;
         dix_ff       <= dix_in;
         face_ff      <= face_in;
         sign_ff      <= sign_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qidx_ff <= qidx_in;
      prod_ff <= prod_in;
      m_ff    <= m_in;
      v_ff    <= v_in;
      r_ff    <= r_in;
      sbit_ff <= sbit_in;
      len_ff  <= len_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      den_ff  <= den_in;
      neg_ff  <= neg_in;
      cnt_ff  <= cnt_in;
      rsp_ff  <= rsp_in;
      for (int i = 0; i < 3; i++) begin
         cidx_ff[i] <= cidx_in[i];
         pa_ff[i]   <= pa_in[i];
         pb_ff[i]   <= pb_in[i];
         pc_ff[i]   <= pc_in[i];
         c_ff[i]    <= c_in[i];
         n_ff[i]    <= n_in[i];
         sum_ff[i]  <= sum_in[i];
      end
      for (int i = 0; i < 6; i++) begin
         e_ff[i] <= e_in[i];
      end
   end

   `MVNA_ASSERT_NEXT(a_strobe_single, rsp_valid_ff, !rsp_valid_ff, "result strobe held")
   `MVNA_ASSERT_IMPL(a_empty_zero, rsp_valid_ff && rsp_ff.no_faces,
      rsp_ff.normal_x == 16'sd0 && rsp_ff.normal_y == 16'sd0 && rsp_ff.normal_z == 16'sd0,
      "vertex without faces returned a nonzero normal")
   `MVNA_ASSERT_IMPL(a_sum_write_src, sum_we, state_ff == ST_AWR || state_ff == ST_CLR,
      "sum store written outside update or clear")
   `MVNA_ASSERT_NEXT(a_face_busy, start && !busy && req_data.kind == mvna_pkg::KIND_FACE,
      busy, "face item did not raise busy")

endmodule

`default_nettype wire

/* sim/mesh_vertex_normal_averager_core_checker.sv */
// Checker for the mesh vertex normal averager: predicts each query result and compares it.
`default_nettype none

module mesh_vertex_normal_averager_core_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire mvna_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire mvna_pkg::rsp_type rsp_data,
   input  wire logic              csr_wen,
   input  wire logic [1:0]        csr_wdata,
   output int                     error_count,
   output int                     pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint SUM_HI = 8388607;
   localparam longint SUM_LO = -8388608;

   logic signed [31:0] pos_x_mem [mvna_pkg::VERTEX_DEPTH];
   logic signed [31:0] pos_y_mem [mvna_pkg::VERTEX_DEPTH];
   logic signed [31:0] pos_z_mem [mvna_pkg::VERTEX_DEPTH];
   longint             acc_x [mvna_pkg::VERTEX_DEPTH];
   longint             acc_y [mvna_pkg::VERTEX_DEPTH];
   longint             acc_z [mvna_pkg::VERTEX_DEPTH];
   int                 faces [mvna_pkg::VERTEX_DEPTH];
   longint             sign_mult;
   mvna_pkg::rsp_type  normal_queue [$];

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic longint div_round(longint num, longint unsigned den);
      longint unsigned q;
      q = (magnitude(num) * 2 + den) / (den * 2);
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint unsigned floor_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   task automatic accumulate_face(int ca, int cb, int cc);
      longint e [6];
      longint c [3];
      longint n [3];
      longint unsigned big, len;
      int sh;
      int corner [3];
      if (ca == 0 || cb == 0 || cc == 0) return;
      if (ca > mvna_pkg::VERTEX_DEPTH || cb > mvna_pkg::VERTEX_DEPTH ||
          cc > mvna_pkg::VERTEX_DEPTH) return;
      corner[0] = ca - 1;
      corner[1] = cb - 1;
      corner[2] = cc - 1;
      e[0] = longint'(pos_x_mem[corner[1]]) - longint'(pos_x_mem[corner[0]]);
      e[1] = longint'(pos_y_mem[corner[1]]) - longint'(pos_y_mem[corner[0]]);
      e[2] = longint'(pos_z_mem[corner[1]]) - longint'(pos_z_mem[corner[0]]);
      e[3] = longint'(pos_x_mem[corner[2]]) - longint'(pos_x_mem[corner[1]]);
      e[4] = longint'(pos_y_mem[corner[2]]) - longint'(pos_y_mem[corner[1]]);
      e[5] = longint'(pos_z_mem[corner[2]]) - longint'(pos_z_mem[corner[1]]);
      // Edges and then the cross product are scaled down together until they fit 30 bits.
      big = 0;
      foreach (e[i]) if (magnitude(e[i]) > big) big = magnitude(e[i]);
      sh = 0;
      while ((big >> sh) >= (64'd1 << 30)) sh++;
      foreach (e[i]) e[i] = e[i] >>> sh;
      c[0] = e[1] * e[5] - e[2] * e[4];
      c[1] = e[2] * e[3] - e[0] * e[5];
      c[2] = e[0] * e[4] - e[1] * e[3];
      big = 0;
      foreach (c[i]) if (magnitude(c[i]) > big) big = magnitude(c[i]);
      sh = 0;
      while ((big >> sh) >= (64'd1 << 30)) sh++;
      foreach (c[i]) c[i] = c[i] >>> sh;
      if (c[0] == 0 && c[1] == 0 && c[2] == 0) return;
      len = floor_sqrt(longint'(c[0] * c[0]) + longint'(c[1] * c[1]) + longint'(c[2] * c[2]));
      if (len == 0) return;
      foreach (n[i]) n[i] = clip(div_round(-c[i] * mvna_pkg::ONE_Q14, len),
                                 -mvna_pkg::ONE_Q14, mvna_pkg::ONE_Q14);
      foreach (corner[k]) begin
         acc_x[corner[k]] = clip(acc_x[corner[k]] + n[0], SUM_LO, SUM_HI);
         acc_y[corner[k]] = clip(acc_y[corner[k]] + n[1], SUM_LO, SUM_HI);
         acc_z[corner[k]] = clip(acc_z[corner[k]] + n[2], SUM_LO, SUM_HI);
         if (faces[corner[k]] < 255) faces[corner[k]]++;
      end
   endtask

   function automatic mvna_pkg::rsp_type averaged_normal(int slot);
      mvna_pkg::rsp_type r;
      longint unsigned den;
      r = '0;
      r.no_faces = 1'b1;
      if (faces[slot] != 0) begin
         den = faces[slot];
         r.normal_x = 16'(clip(div_round(sign_mult * acc_x[slot], den),
                               -mvna_pkg::ONE_Q14, mvna_pkg::ONE_Q14));
         r.normal_y = 16'(clip(div_round(sign_mult * acc_y[slot], den),
                               -mvna_pkg::ONE_Q14, mvna_pkg::ONE_Q14));
         r.normal_z = 16'(clip(div_round(sign_mult * acc_z[slot], den),
                               -mvna_pkg::ONE_Q14, mvna_pkg::ONE_Q14));
         r.no_faces = 1'b0;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      mvna_pkg::rsp_type want;
      if (reset) begin
         foreach (faces[i]) begin
            acc_x[i] = 0;
            acc_y[i] = 0;
            acc_z[i] = 0;
            faces[i] = 0;
         end
         sign_mult = 1;
         error_count = 0;
         normal_queue.delete();
      end else begin
         if (csr_wen) sign_mult = longint'($signed(csr_wdata));
         if (start && !busy) begin
            case (req_data.kind)
               mvna_pkg::KIND_STORE: begin
                  pos_x_mem[req_data.vertex_index] = req_data.pos_x;
                  pos_y_mem[req_data.vertex_index] = req_data.pos_y;
                  pos_z_mem[req_data.vertex_index] = req_data.pos_z;
               end
               mvna_pkg::KIND_FACE: accumulate_face(req_data.corner_a, req_data.corner_b,
                                                    req_data.corner_c);
               mvna_pkg::KIND_QUERY:
                  normal_queue.push_back(averaged_normal(int'(req_data.vertex_index)));
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (normal_queue.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual %h", $realtime,
                        rsp_data);
               error_count++;
            end else begin
               want = normal_queue.pop_front();
               if (rsp_data.normal_x !== want.normal_x ||
                   rsp_data.normal_y !== want.normal_y ||
                   rsp_data.normal_z !== want.normal_z ||
                   rsp_data.no_faces !== want.no_faces) begin
                  $display({"%0t: normal mismatch, expected x=%0d y=%0d z=%0d nf=%0d,",
                            " actual x=%0d y=%0d z=%0d nf=%0d"},
                           $realtime, want.normal_x, want.normal_y, want.normal_z,
                           want.no_faces, rsp_data.normal_x, rsp_data.normal_y,
                           rsp_data.normal_z, rsp_data.no_faces);
                  error_count++;
               end
            end
         end
      end
      pending = normal_queue.size();
   end

endmodule

`default_nettype wire

/* sim/mesh_vertex_normal_averager_core_tb.sv */
// Testbench top for the mesh vertex normal averager: stimulus, watchdog and verdict.
`default_nettype none

module mesh_vertex_normal_averager_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IDLE_LIMIT  = 20000;
   localparam int FACE_SETTLE = 300;
   localparam int POOL        = 48;
   localparam logic [1:0] KIND_NOP = 2'd3;

   logic              clock;
   logic              reset;
   logic              start;
   logic              busy;
   mvna_pkg::req_type req_data;
   logic              rsp_valid;
   mvna_pkg::rsp_type rsp_data;
   logic              csr_wen;
   logic [1:0]        csr_wdata;
   int                error_count;
   int                pending;
   int                idle_cycles;
   int                burst_left;
   bit                is_written [mvna_pkg::VERTEX_DEPTH];
   int                written_list [$];

   mesh_vertex_normal_averager_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_wen(csr_wen), .csr_wdata(csr_wdata)
   );

   mesh_vertex_normal_averager_core_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_wen(csr_wen), .csr_wdata(csr_wdata),
      .error_count(error_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("mesh_vertex_normal_averager_core_tb NOT OK");
            $finish;
         end
      end
   end

   function automatic mvna_pkg::req_type noise_item();
      logic [159:0] bits;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom};
      return bits[$bits(mvna_pkg::req_type)-1:0];
   endfunction

   // Called at a falling edge; returns at the falling edge after the item is taken.
   task automatic send(mvna_pkg::req_type r);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      start    <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      if (r.kind == mvna_pkg::KIND_STORE && !is_written[r.vertex_index]) begin
         is_written[r.vertex_index] = 1'b1;
         written_list.push_back(int'(r.vertex_index));
      end
      @(negedge clock);
   endtask

   task automatic store_vertex(int slot, logic [31:0] x, logic [31:0] y, logic [31:0] z);
      mvna_pkg::req_type r;
      r = noise_item();
      r.kind = mvna_pkg::KIND_STORE;
      r.vertex_index = 12'(slot);
      r.pos_x = x;
      r.pos_y = y;
      r.pos_z = z;
      send(r);
   endtask

   task automatic face(int a, int b, int c);
      mvna_pkg::req_type r;
      r = noise_item();
      r.kind = mvna_pkg::KIND_FACE;
      r.corner_a = 13'(a);
      r.corner_b = 13'(b);
      r.corner_c = 13'(c);
      send(r);
   endtask

   task automatic query(int slot);
      mvna_pkg::req_type r;
      r = noise_item();
      r.kind = mvna_pkg::KIND_QUERY;
      r.vertex_index = 12'(slot);
      send(r);
   endtask

   // Register writes happen only once the block has drained.
   task automatic write_sign(logic [1:0] value);
      start <= 1'b0;
      burst_left = 0;
      while (pending != 0) @(negedge clock);
      repeat (FACE_SETTLE) @(negedge clock);
      csr_wen   <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen   <= 1'b0;
   endtask

   function automatic int pick_corner();
      return written_list[$urandom_range(0, written_list.size() - 1)] + 1;
   endfunction

   function automatic logic [31:0] random_coord();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return 32'($signed($urandom_range(0, 16'hffff)) - 32768) <<< 4;
         default: return 32'($signed($urandom_range(0, 24'hffffff)) - 24'h800000);
      endcase
   endfunction

   task automatic random_items(int total);
      int slot;
      int pick;
      for (int n = 0; n < total; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            slot = ($urandom_range(0, 7) == 0) ?
                   $urandom_range(0, mvna_pkg::VERTEX_DEPTH - 1) : $urandom_range(0, POOL - 1);
            store_vertex(slot, random_coord(), random_coord(), random_coord());
         end else if (pick < 62) begin
            face(pick_corner(), pick_corner(), pick_corner());
         end else if (pick < 66) begin
            // Bad corners: zero or past the last vertex.
            face(($urandom_range(0, 1) == 0) ? 0 :
                 $urandom_range(mvna_pkg::VERTEX_DEPTH + 1, 8191),
                 pick_corner(), pick_corner());
         end else if (pick < 69) begin
            slot = pick_corner();
            face(slot, slot, pick_corner());
         end else if (pick < 95) begin
            slot = ($urandom_range(0, 5) == 0) ?
                   $urandom_range(0, mvna_pkg::VERTEX_DEPTH - 1) : $urandom_range(0, POOL - 1);
            query(slot);
         end else begin
            mvna_pkg::req_type r;
            r = noise_item();
            r.kind = KIND_NOP;
            send(r);
         end
      end
   endtask

   initial begin
      mvna_pkg::req_type r;
      reset       = 1'b1;
      start       = 1'b0;
      req_data    = '0;
      csr_wen     = 1'b0;
      csr_wdata   = 2'b01;
      burst_left  = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part: extremes, corner 4096, degenerate and bad faces, empty queries.
      store_vertex(0, 32'h0, 32'h0, 32'h0);
      store_vertex(1, 32'h0001_0000, 32'h0, 32'h0);
      store_vertex(2, 32'h0, 32'h0001_0000, 32'h0);
      store_vertex(3, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      store_vertex(4, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
      store_vertex(5, 32'h0002_0000, 32'h0, 32'h0);
      store_vertex(mvna_pkg::VERTEX_DEPTH - 1, 32'h8000_0000, 32'h7fff_ffff, 32'h0);
      face(1, 2, 3);
      face(mvna_pkg::VERTEX_DEPTH, 4, 5);
      face(1, 2, 6);
      face(1, 1, 3);
      face(0, 2, 3);
      face(mvna_pkg::VERTEX_DEPTH + 1, 2, 3);
      face(8191, 8191, 8191);
      query(0);
      query(mvna_pkg::VERTEX_DEPTH - 1);
      query(3);
      query(100);
      r = noise_item();
      r.kind = KIND_NOP;
      send(r);
      write_sign(2'b11);
      query(0);
      query(3);
      write_sign(2'b00);
      query(0);
      write_sign(2'b01);

      // Drive the corners of one face past count and sum saturation.
      for (int k = 0; k < 530; k++) face(1, 2, 3);
      query(0);
      query(1);

      for (int s = 0; s < POOL; s++)
         store_vertex(s, random_coord(), random_coord(), random_coord());
      random_items(100);
      write_sign(2'b11);
      random_items(100);
      write_sign(2'b00);
      random_items(40);
      write_sign(2'b01);
      random_items(60);

      start <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (FACE_SETTLE) @(negedge clock);
      if (error_count == 0) begin
         $display("mesh_vertex_normal_averager_core_tb OK");
      end else begin
         $display("mesh_vertex_normal_averager_core_tb NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* filelist.f */
+incdir+sv
sv/mvna_pkg.sv
sv/mesh_vertex_normal_averager_core.sv
sim/mesh_vertex_normal_averager_core_checker.sv
sim/mesh_vertex_normal_averager_core_tb.sv
